// File: design/binary_projection_histogram_defines.svh
// Assertion macros shared by the histogram RTL.
`ifndef BINARY_PROJECTION_HISTOGRAM_DEFINES_SVH
`define BINARY_PROJECTION_HISTOGRAM_DEFINES_SVH

`ifndef SYNTHESIS

`define BPH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BPH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BPH_ASSERT(lbl, clk, rst_n, prop, msg)

`define BPH_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: design/bph_pkg.sv
`timescale 1ns / 1ps

package bph_pkg;

    localparam int COUNT_W   = 7;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
    localparam logic [DIM_W-1:0]   DIM_RESET = 7'd64;

    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_RD,
        ST_RD_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic acc_wr;
        logic resp;
        logic clr_step;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
    } stat_t;

endpackage

// File: design/bph_ram.sv
`timescale 1ns / 1ps

module bph_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/bph_ctrl.sv
`timescale 1ns / 1ps
`include "binary_projection_histogram_defines.svh"

module bph_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         operation,
    input  bph_pkg::stat_t     stat,
    output bph_pkg::cmd_t      cmd,
    output logic               busy
);

    bph_pkg::state_t state_reg;
    bph_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bph_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bph_pkg::ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = bph_pkg::ST_IDLE;
                end
            end
            bph_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (operation)
                        bph_pkg::OP_ACC:   state_next = bph_pkg::ST_ACC_RD;
                        bph_pkg::OP_READ:  state_next = bph_pkg::ST_RD_RD;
                        bph_pkg::OP_CLEAR: state_next = bph_pkg::ST_CLEAR;
                        default:           state_next = bph_pkg::ST_IDLE;
                    endcase
                end
            end
            bph_pkg::ST_ACC_RD:  state_next = bph_pkg::ST_ACC_WR;
            bph_pkg::ST_ACC_WR:  state_next = bph_pkg::ST_IDLE;
            bph_pkg::ST_RD_RD:   state_next = bph_pkg::ST_RD_RESP;
            bph_pkg::ST_RD_RESP: state_next = bph_pkg::ST_IDLE;
            default:             state_next = bph_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            bph_pkg::ST_CLEAR:   cmd.clr_step = 1'b1;
            bph_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            bph_pkg::ST_ACC_RD:  cmd.rd_en  = 1'b1;
            bph_pkg::ST_ACC_WR:  cmd.acc_wr = 1'b1;
            bph_pkg::ST_RD_RD:   cmd.rd_en  = 1'b1;
            bph_pkg::ST_RD_RESP: cmd.resp   = 1'b1;
            default:             busy       = 1'b1;
        endcase
    end

    `BPH_ASSERT(a_read_resp, clk, rst_n, (start && !busy && operation == bph_pkg::OP_READ) |-> ##2 cmd.resp, "read item did not reach response")
    `BPH_ASSERT(a_clear_busy, clk, rst_n, cmd.clr_step |-> busy, "clear sweep while not busy")
    `BPH_ASSERT(a_acc_seq, clk, rst_n, cmd.acc_wr |-> $past(cmd.rd_en), "counter write without preceding read")

endmodule

// File: design/bph_dp.sv
`timescale 1ns / 1ps
`include "binary_projection_histogram_defines.svh"

module bph_dp #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bph_pkg::cmd_t                     cmd,
    output bph_pkg::stat_t                    stat,
    input  logic [1:0]                        operation,
    input  logic [15:0]                       pixel_label,
    input  logic [5:0]                        pixel_row,
    input  logic [5:0]                        pixel_col,
    input  logic [6:0]                        bin_index,
    input  logic                              cfg_valid,
    input  logic [bph_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bph_pkg::DIM_W-1:0]         cfg_data,
    output logic                              done,
    output logic [bph_pkg::COUNT_W-1:0]       bin_count,
    output logic                              bad_index
);

    localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MAXD   = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int CLR_W  = (MAXD > 1) ? $clog2(MAXD) : 1;

    logic [bph_pkg::DIM_W-1:0]   height_reg;
    logic [bph_pkg::DIM_W-1:0]   width_reg;
    logic [bph_pkg::DIM_W-1:0]   h_eff;
    logic [bph_pkg::DIM_W-1:0]   w_eff;
    logic [bph_pkg::DIM_W:0]     hw_sum;

    logic [ROW_AW-1:0]           row_addr_reg;
    logic [ROW_AW-1:0]           row_addr_next;
    logic [COL_AW-1:0]           col_addr_reg;
    logic [COL_AW-1:0]           col_addr_next;
    logic                        acc_ok_reg;
    logic                        acc_ok_next;
    logic                        in_row_reg;
    logic                        in_row_next;
    logic                        in_col_reg;
    logic                        in_col_next;

    logic [CLR_W-1:0]            clr_cnt_reg;
    logic [CLR_W-1:0]            clr_cnt_next;

    logic                        done_reg;
    logic [bph_pkg::COUNT_W-1:0] bin_count_reg;
    logic [bph_pkg::COUNT_W-1:0] bin_count_next;
    logic                        bad_index_reg;

    logic                        row_we;
    logic [ROW_AW-1:0]           row_waddr;
    logic [bph_pkg::COUNT_W-1:0] row_wdata;
    logic [bph_pkg::COUNT_W-1:0] row_rdata;
    logic                        col_we;
    logic [COL_AW-1:0]           col_waddr;
    logic [bph_pkg::COUNT_W-1:0] col_wdata;
    logic [bph_pkg::COUNT_W-1:0] col_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= bph_pkg::DIM_RESET;
            width_reg  <= bph_pkg::DIM_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bph_pkg::REG_HEIGHT: height_reg <= cfg_data;
                bph_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign h_eff  = (32'(height_reg) > MAX_HEIGHT) ? bph_pkg::DIM_W'(MAX_HEIGHT) : height_reg;
    assign w_eff  = (32'(width_reg) > MAX_WIDTH) ? bph_pkg::DIM_W'(MAX_WIDTH) : width_reg;
    assign hw_sum = {1'b0, h_eff} + {1'b0, w_eff};

    // latch item: addresses and bin selection
    always_comb
    begin
        acc_ok_next = (pixel_label != 16'd0) && ({1'b0, pixel_row} < h_eff)
                      && ({1'b0, pixel_col} < w_eff);
        in_row_next = (bin_index < h_eff);
        in_col_next = !in_row_next && ({1'b0, bin_index} < hw_sum);
        if (operation == bph_pkg::OP_READ)
        begin
            row_addr_next = ROW_AW'(bin_index);
            col_addr_next = COL_AW'(bin_index - h_eff);
        end
        else
        begin
            row_addr_next = ROW_AW'(pixel_row);
            col_addr_next = COL_AW'(pixel_col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_addr_reg <= row_addr_next;
            col_addr_reg <= col_addr_next;
            acc_ok_reg   <= acc_ok_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
        end
    end

    assign clr_cnt_next  = stat.clr_last ? '0 : clr_cnt_reg + 1'b1;
    assign stat.clr_last = (clr_cnt_reg == CLR_W'(MAXD - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // write port: clearing sweep or saturating increment
    always_comb
    begin
        if (cmd.clr_step)
        begin
            row_we    = (32'(clr_cnt_reg) < MAX_HEIGHT);
            row_waddr = ROW_AW'(clr_cnt_reg);
            row_wdata = '0;
            col_we    = (32'(clr_cnt_reg) < MAX_WIDTH);
            col_waddr = COL_AW'(clr_cnt_reg);
            col_wdata = '0;
        end
        else
        begin
            row_we    = cmd.acc_wr && acc_ok_reg;
            row_waddr = row_addr_reg;
            row_wdata = (row_rdata == bph_pkg::COUNT_MAX) ? row_rdata : row_rdata + 1'b1;
            col_we    = cmd.acc_wr && acc_ok_reg;
            col_waddr = col_addr_reg;
            col_wdata = (col_rdata == bph_pkg::COUNT_MAX) ? col_rdata : col_rdata + 1'b1;
        end
    end

    bph_ram #(
        .WIDTH (bph_pkg::COUNT_W),
        .DEPTH (MAX_HEIGHT)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (cmd.rd_en),
        .raddr (row_addr_reg),
        .rdata (row_rdata)
    );

    bph_ram #(
        .WIDTH (bph_pkg::COUNT_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .re    (cmd.rd_en),
        .raddr (col_addr_reg),
        .rdata (col_rdata)
    );

    always_comb
    begin
        if (in_row_reg)
        begin
            bin_count_next = row_rdata;
        end
        else if (in_col_reg)
        begin
            bin_count_next = col_rdata;
        end
        else
        begin
            bin_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.resp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            bin_count_reg <= bin_count_next;
            bad_index_reg <= !in_row_reg && !in_col_reg;
        end
    end

    assign done      = done_reg;
    assign bin_count = bin_count_reg;
    assign bad_index = bad_index_reg;

    `BPH_ASSERT(a_bad_zero, clk, rst_n, (done_reg && bad_index_reg) |-> (bin_count_reg == '0), "bad index with nonzero count")
    `BPH_ASSERT(a_wr_excl, clk, rst_n, !(cmd.acc_wr && cmd.clr_step), "increment during clearing sweep")
    `BPH_ASSERT(a_sel_excl, clk, rst_n, cmd.resp |-> !(in_row_reg && in_col_reg), "bin selects both profiles")

endmodule

// File: design/binary_projection_histogram.sv
`timescale 1ns / 1ps
// Row/column projection profile unit.
// Input: an item is taken at a rising edge with start high and busy low.
//   operation selects accumulate (count a nonzero pixel into its row and
//   column bins), read (return one bin: rows first, then columns) or clear.
// Output: a read returns bin_count and bad_index, valid for one cycle while
//   done is high; they are registered from the RAM read in the response
//   state. The receiver cannot stall; results are not held.
// Sequencing: accumulate keeps busy high after the accept through a RAM
//   read and a write-back (a read-modify-write on each profile RAM), and
//   read through a RAM read and a response state. Clear keeps busy high
//   after the accept while one bin of each profile is zeroed per cycle,
//   up to max(MAX_HEIGHT, MAX_WIDTH) bins. Reset: the same clearing sweep
//   runs with busy high; proj_height and proj_width return to 64.
// Config: cfg_ready is always high; write index 0 for proj_height and 1 for
//   proj_width, only while the block is idle.

module binary_projection_histogram #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [15:0]                   pixel_label,
    input  logic [5:0]                    pixel_row,
    input  logic [5:0]                    pixel_col,
    input  logic [6:0]                    bin_index,
    output logic                          done,
    output logic [bph_pkg::COUNT_W-1:0]   bin_count,
    output logic                          bad_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bph_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bph_pkg::DIM_W-1:0]     cfg_data
);

    bph_pkg::cmd_t  cmd;
    bph_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    bph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    bph_dp #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .pixel_label (pixel_label),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .bin_index   (bin_index),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .bin_count   (bin_count),
        .bad_index   (bad_index)
    );

endmodule
